@@ design/ray_box_slab_intersection_assert.svh @@
// Assertion macros shared by the ray/box slab test modules
`ifndef RAY_BOX_SLAB_INTERSECTION_ASSERT_SVH
`define RAY_BOX_SLAB_INTERSECTION_ASSERT_SVH

// same-cycle implication
`define RBSI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RBSI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/rbsi_pkg.sv @@
// Package: shared types and constants of the ray/box slab test
`timescale 1ns / 1ps
package rbsi_pkg;

	localparam int unsigned AXES        = 3;
	localparam int unsigned QBITS       = 32;
	localparam int unsigned BPS         = 2;
	localparam int unsigned DIV_STAGES  = QBITS / BPS;
	localparam int unsigned RECIP_SHIFT = 30;
	localparam int unsigned CFG_IDX_W   = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_LOW  = 3'd0,
		REG_X_HIGH = 3'd1,
		REG_Y_LOW  = 3'd2,
		REG_Y_HIGH = 3'd3,
		REG_Z_LOW  = 3'd4,
		REG_Z_HIGH = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OUT_HIT_AHEAD   = 2'd0,
		OUT_MISS_AHEAD  = 2'd1,
		OUT_HIT_BEHIND  = 2'd2,
		OUT_MISS_BEHIND = 2'd3
	} outcome_t;

	// one classified ray as queued between front and back
	typedef struct packed {
		logic [AXES-1:0]             dneg;
		logic [AXES-1:0][15:0]       dmag;
		logic [AXES-1:0][32:0]       dlo;
		logic [AXES-1:0][32:0]       dhi;
	} ray_item_t;

	typedef logic signed [47:0] dist_t;

endpackage

@@ design/rbsi_front.sv @@
// Front: box registers, config port and ray classification
`timescale 1ns / 1ps
module rbsi_front (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              cfg_valid,
	input  logic [rbsi_pkg::CFG_IDX_W-1:0]                    cfg_index,
	input  logic [31:0]                                       cfg_data,
	input  logic [rbsi_pkg::AXES-1:0][31:0]                   origin,
	input  logic [rbsi_pkg::AXES-1:0][15:0]                   dir,
	output rbsi_pkg::ray_item_t                               item
);

	logic [rbsi_pkg::AXES-1:0][1:0][31:0] box_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q <= '0;
		end else if (cfg_valid) begin
			case (rbsi_pkg::cfg_reg_t'(cfg_index))
				rbsi_pkg::REG_X_LOW: begin
					box_q[0][0] <= cfg_data;
				end
				rbsi_pkg::REG_X_HIGH: begin
					box_q[0][1] <= cfg_data;
				end
				rbsi_pkg::REG_Y_LOW: begin
					box_q[1][0] <= cfg_data;
				end
				rbsi_pkg::REG_Y_HIGH: begin
					box_q[1][1] <= cfg_data;
				end
				rbsi_pkg::REG_Z_LOW: begin
					box_q[2][0] <= cfg_data;
				end
				rbsi_pkg::REG_Z_HIGH: begin
					box_q[2][1] <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		logic [15:0] d;
		item = '0;
		for (int a = 0; a < rbsi_pkg::AXES; a++) begin
			// zero direction counts as one LSB
			d = (dir[a] == '0) ? 16'd1 : dir[a];
			item.dneg[a] = d[15];
			item.dmag[a] = d[15] ? (~d + 16'd1) : d;
			item.dlo[a]  = {box_q[a][0][31], box_q[a][0]} - {origin[a][31], origin[a]};
			item.dhi[a]  = {box_q[a][1][31], box_q[a][1]} - {origin[a][31], origin[a]};
		end
	end

endmodule

@@ design/rbsi_fifo.sv @@
// Short request queue between front and back
`timescale 1ns / 1ps
`include "ray_box_slab_intersection_assert.svh"
module rbsi_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  rbsi_pkg::ray_item_t push_data,
	output logic                full,
	input  logic                pop,
	output rbsi_pkg::ray_item_t pop_data,
	output logic                not_empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	rbsi_pkg::ray_item_t mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_q;
	logic [PTR_W-1:0]    rd_q;
	logic [CNT_W-1:0]    count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10: begin
					count_q <= count_q + 1'b1;
				end
				2'b01: begin
					count_q <= count_q - 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	`RBSI_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(DEPTH), "queue overfilled")
	`RBSI_ASSERT_IMP(a_pop_nonempty, clk, arst_n, pop, count_q != '0, "pop from empty queue")
	`RBSI_ASSERT_NXT(a_cnt_inc, clk, arst_n, push && !pop, count_q == $past(count_q) + 1'b1, "count lost a push")

endmodule

@@ design/rbsi_recip.sv @@
// Pipelined reciprocal 2^30 / mag, two quotient bits per stage
`timescale 1ns / 1ps
module rbsi_recip (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic [rbsi_pkg::AXES-1:0][15:0]        mag,
	output logic [rbsi_pkg::AXES-1:0][30:0]        quo
);

	localparam int unsigned NST = rbsi_pkg::DIV_STAGES;
	localparam int unsigned QW  = rbsi_pkg::QBITS;

	logic [rbsi_pkg::AXES-1:0][15:0]   rem_s [NST];
	logic [rbsi_pkg::AXES-1:0][QW-1:0] quo_s [NST];
	logic [rbsi_pkg::AXES-1:0][15:0]   mag_s [NST];

	for (genvar st = 0; st < NST; st++) begin : g_st
		logic [rbsi_pkg::AXES-1:0][15:0]   rem_prev;
		logic [rbsi_pkg::AXES-1:0][QW-1:0] quo_prev;
		logic [rbsi_pkg::AXES-1:0][15:0]   mag_prev;
		logic [rbsi_pkg::AXES-1:0][15:0]   rem_nxt;
		logic [rbsi_pkg::AXES-1:0][QW-1:0] quo_nxt;

		if (st == 0) begin : g_first
			assign rem_prev = '0;
			assign quo_prev = '0;
			assign mag_prev = mag;
		end else begin : g_rest
			assign rem_prev = rem_s[st-1];
			assign quo_prev = quo_s[st-1];
			assign mag_prev = mag_s[st-1];
		end

		always_comb begin
			logic [16:0]   r;
			logic [15:0]   rc;
			logic [QW-1:0] qc;
			logic          nbit;
			for (int a = 0; a < rbsi_pkg::AXES; a++) begin
				rc = rem_prev[a];
				qc = quo_prev[a];
				for (int k = 0; k < rbsi_pkg::BPS; k++) begin
					// dividend has a single set bit
					nbit = ((QW - 1 - st * rbsi_pkg::BPS - k) == rbsi_pkg::RECIP_SHIFT);
					r = {rc, nbit};
					if (r >= {1'b0, mag_prev[a]}) begin
						r  = r - {1'b0, mag_prev[a]};
						qc = {qc[QW-2:0], 1'b1};
					end else begin
						qc = {qc[QW-2:0], 1'b0};
					end
					rc = r[15:0];
				end
				rem_nxt[a] = rc;
				quo_nxt[a] = qc;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[st] <= rem_nxt;
				quo_s[st] <= quo_nxt;
				mag_s[st] <= mag_prev;
			end
		end
	end

	always_comb begin
		for (int a = 0; a < rbsi_pkg::AXES; a++) begin
			quo[a] = quo_s[NST-1][a][30:0];
		end
	end

endmodule

@@ design/rbsi_back.sv @@
// Back: reciprocal, plane distances, slab reduction and result register
`timescale 1ns / 1ps
`include "ray_box_slab_intersection_assert.svh"
module rbsi_back (
	input  logic                clk,
	input  logic                arst_n,
	input  rbsi_pkg::ray_item_t item,
	input  logic                item_valid,
	output logic                pop,
	input  logic                res_stall,
	output logic                res_valid,
	output logic signed [31:0]  distance,
	output logic [1:0]          outcome,
	output logic                inside_res
);

	localparam int unsigned NST = rbsi_pkg::DIV_STAGES;
	localparam int unsigned AX  = rbsi_pkg::AXES;

	logic en;
	logic [AX-1:0][30:0] quo;

	rbsi_pkg::ray_item_t pay_s [NST];
	logic [NST-1:0]      vld_s;

	logic [AX-1:0][1:0][31:0] amag_s1;
	logic [AX-1:0][1:0]       neg_s1;
	logic [AX-1:0][30:0]      quo_s1;
	logic [AX-1:0][1:0][46:0] ph_s2;
	logic [AX-1:0][1:0][46:0] pl_s2;
	logic [AX-1:0][1:0]       neg_s2;
	logic [AX-1:0][1:0][46:0] m_s3;
	logic [AX-1:0][1:0]       neg_s3;
	rbsi_pkg::dist_t          t_s4    [AX][2];
	rbsi_pkg::dist_t          tmin_s5 [AX];
	rbsi_pkg::dist_t          tmax_s5 [AX];
	rbsi_pkg::dist_t          near_s6;
	rbsi_pkg::dist_t          far_s6;
	logic                     vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic signed [31:0]       dist_s7;
	rbsi_pkg::outcome_t       outc_s7;
	logic                     inside_s7;

	assign en  = !vld_s7 || !res_stall;
	assign pop = en && item_valid;

	rbsi_recip u_recip (
		.clk (clk),
		.en  (en),
		.mag (item.dmag),
		.quo (quo)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s[0] <= item;
			for (int s = 1; s < NST; s++) begin
				pay_s[s] <= pay_s[s-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s  <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s  <= {vld_s[NST-2:0], item_valid};
			vld_s1 <= vld_s[NST-1];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// plane distance magnitudes, split products, sign, then per-axis min/max and slab reduction
	always_ff @(posedge clk) begin
		rbsi_pkg::dist_t mx;
		rbsi_pkg::dist_t mn;
		logic [32:0] df;
		if (en) begin
			for (int a = 0; a < AX; a++) begin
				quo_s1[a] <= quo[a];
				for (int p = 0; p < 2; p++) begin
					df = (p == 0) ? pay_s[NST-1].dlo[a] : pay_s[NST-1].dhi[a];
					amag_s1[a][p] <= df[32] ? 32'(~df + 33'd1) : df[31:0];
					neg_s1[a][p]  <= df[32] ^ pay_s[NST-1].dneg[a];
					ph_s2[a][p]   <= 47'(amag_s1[a][p][31:16] * quo_s1[a]);
					pl_s2[a][p]   <= 47'(amag_s1[a][p][15:0] * quo_s1[a]);
					m_s3[a][p]    <= ph_s2[a][p] + 47'(pl_s2[a][p][46:16]);
					t_s4[a][p]    <= neg_s3[a][p] ? -$signed({1'b0, m_s3[a][p]})
					                              :  $signed({1'b0, m_s3[a][p]});
				end
				neg_s2[a] <= neg_s1[a];
				neg_s3[a] <= neg_s2[a];
				if (t_s4[a][0] < t_s4[a][1]) begin
					tmin_s5[a] <= t_s4[a][0];
					tmax_s5[a] <= t_s4[a][1];
				end else begin
					tmin_s5[a] <= t_s4[a][1];
					tmax_s5[a] <= t_s4[a][0];
				end
			end
			mx = tmin_s5[0];
			mn = tmax_s5[0];
			for (int a = 1; a < AX; a++) begin
				if (tmin_s5[a] > mx) begin
					mx = tmin_s5[a];
				end
				if (tmax_s5[a] < mn) begin
					mn = tmax_s5[a];
				end
			end
			near_s6 <= mx;
			far_s6  <= mn;
		end
	end

	always_ff @(posedge clk) begin
		rbsi_pkg::dist_t sel;
		logic            miss;
		if (en) begin
			miss = near_s6 > far_s6;
			sel  = far_s6[47] ? far_s6 : near_s6;
			if (far_s6[47]) begin
				outc_s7 <= miss ? rbsi_pkg::OUT_MISS_BEHIND : rbsi_pkg::OUT_HIT_BEHIND;
			end else begin
				outc_s7 <= miss ? rbsi_pkg::OUT_MISS_AHEAD : rbsi_pkg::OUT_HIT_AHEAD;
			end
			inside_s7 <= !miss && !far_s6[47] && (far_s6 != '0) && near_s6[47];
			if (miss) begin
				dist_s7 <= '0;
			end else if (sel[47:31] == {17{sel[47]}}) begin
				dist_s7 <= sel[31:0];
			end else begin
				dist_s7 <= sel[47] ? 32'sh8000_0000 : 32'sh7fff_ffff;
			end
		end
	end

	assign res_valid  = vld_s7;
	assign distance   = dist_s7;
	assign outcome    = outc_s7;
	assign inside_res = inside_s7;

	`RBSI_ASSERT_IMP(a_inside_hit, clk, arst_n, res_valid && inside_res, outcome == rbsi_pkg::OUT_HIT_AHEAD, "inside without a hit ahead")
	`RBSI_ASSERT_IMP(a_miss_zero, clk, arst_n, res_valid && outcome[0], distance == '0, "miss with nonzero distance")
	`RBSI_ASSERT_IMP(a_behind_neg, clk, arst_n, res_valid && (outcome == rbsi_pkg::OUT_HIT_BEHIND), distance[31], "hit behind with non-negative distance")

endmodule

@@ design/ray_box_slab_intersection.sv @@
// Top level: ray versus axis-aligned box slab test
// Usage:
//  Write the six box corners (signed Q16.16) over the cfg channel: index 0..5 is
//  x low, x high, y low, y high, z low, z high; other indices are ignored.
//  cfg_ready is always high. Write only while no ray is in flight.
//  Rays enter on ray_valid/ray_stall: origin Q16.16, direction Q2.14.
//  Each ray gives one result on res_valid/res_stall: distance (Q16.16,
//  saturated, zero on a miss), outcome code and inside flag.
// Timing:
//  One ray per cycle sustained while res_stall is low. An accepted ray waits in
//  the queue until its head is popped into the 16-stage pipelined reciprocal
//  (two quotient bits per stage), then passes 7 registers for the distance
//  products, slab reduction and result before res_valid.
// Stall: res_stall with res_valid high freezes the whole back pipeline;
//  the queue keeps taking rays until full, then ray_stall rises.
// Reset: arst_n clears the box registers to zero, empties the queue and
//  drops every valid bit.
`timescale 1ns / 1ps
module ray_box_slab_intersection #(
	parameter int unsigned FIFO_DEPTH = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rbsi_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [31:0]                         cfg_data,
	input  logic                                ray_valid,
	output logic                                ray_stall,
	input  logic signed [31:0]                  origin_x,
	input  logic signed [31:0]                  origin_y,
	input  logic signed [31:0]                  origin_z,
	input  logic signed [15:0]                  dir_x,
	input  logic signed [15:0]                  dir_y,
	input  logic signed [15:0]                  dir_z,
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic signed [31:0]                  distance,
	output logic [1:0]                          outcome,
	output logic                                inside_res
);

	rbsi_pkg::ray_item_t front_item;
	rbsi_pkg::ray_item_t queue_item;
	logic                q_full;
	logic                q_nempty;
	logic                q_pop;

	assign cfg_ready = 1'b1;
	assign ray_stall = q_full;

	rbsi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.origin    ({origin_z, origin_y, origin_x}),
		.dir       ({dir_z, dir_y, dir_x}),
		.item      (front_item)
	);

	rbsi_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (ray_valid && !q_full),
		.push_data (front_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (queue_item),
		.not_empty (q_nempty)
	);

	rbsi_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (queue_item),
		.item_valid (q_nempty),
		.pop        (q_pop),
		.res_stall  (res_stall),
		.res_valid  (res_valid),
		.distance   (distance),
		.outcome    (outcome),
		.inside_res (inside_res)
	);

endmodule

@@ verif/testbench.sv @@
// Testbench for the ray versus axis-aligned box slab test block
`timescale 1ns / 1ps
module testbench;

	typedef struct {
		logic signed [31:0]   dist_val;
		rbsi_pkg::outcome_t   code;
		logic                 in_box;
	} slab_res_t;

	typedef struct {
		logic signed [31:0] ox, oy, oz;
		logic signed [15:0] dx, dy, dz;
		bit                 has_exp;
		slab_res_t          exp_res;
	} ray_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [rbsi_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic ray_valid = 0;
	logic ray_stall;
	logic signed [31:0] origin_x = 0, origin_y = 0, origin_z = 0;
	logic signed [15:0] dir_x = 0, dir_y = 0, dir_z = 0;
	logic res_valid;
	logic res_stall = 0;
	logic signed [31:0] distance;
	logic [1:0] outcome;
	logic inside_res;

	ray_box_slab_intersection DUT (.*);

	logic signed [31:0] box_corner [6];
	slab_res_t pending_hits [$];
	int errors = 0;
	int cycles = 0;
	bit calm = 0;
	localparam int CYCLE_LIMIT = 400000;

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// per-axis plane distance, truncated toward zero
	function automatic logic signed [63:0] plane_t(logic signed [63:0] diff,
			logic signed [63:0] inv);
		logic [63:0] a, b, m;
		a = diff < 0 ? -diff : diff;
		b = inv < 0 ? -inv : inv;
		m = (a * b) >> 16;
		return ((diff < 0) != (inv < 0)) ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'h7fffffff;
		if (v < -64'sd2147483648) return 32'h80000000;
		return v[31:0];
	endfunction

	function automatic slab_res_t slab_hit(ray_row_t r);
		slab_res_t res;
		logic signed [63:0] org, d, inv, t0, t1, tmin, tmax, tnear, tfar;
		logic [63:0] mag;
		tnear = 0;
		tfar = 0;
		for (int ax = 0; ax < 3; ax++) begin
			org = ax == 0 ? r.ox : ax == 1 ? r.oy : r.oz;
			d = ax == 0 ? r.dx : ax == 1 ? r.dy : r.dz;
			if (d == 0) d = 1;
			mag = d < 0 ? -d : d;
			inv = $signed((64'd1 << 30) / mag);
			if (d < 0) inv = -inv;
			t0 = plane_t(box_corner[2*ax] - org, inv);
			t1 = plane_t(box_corner[2*ax+1] - org, inv);
			tmin = t0 < t1 ? t0 : t1;
			tmax = t0 < t1 ? t1 : t0;
			if (ax == 0 || tmin > tnear) tnear = tmin;
			if (ax == 0 || tmax < tfar) tfar = tmax;
		end
		res.dist_val = 0;
		res.in_box = 0;
		if (tfar < 0) begin
			if (tnear > tfar) res.code = rbsi_pkg::OUT_MISS_BEHIND;
			else begin
				res.code = rbsi_pkg::OUT_HIT_BEHIND;
				res.dist_val = clamp32(tfar);
			end
		end else if (tnear > tfar) res.code = rbsi_pkg::OUT_MISS_AHEAD;
		else begin
			res.code = rbsi_pkg::OUT_HIT_AHEAD;
			res.dist_val = clamp32(tnear);
			res.in_box = tfar > 0 && tnear < 0;
		end
		return res;
	endfunction

	// valid stays high across a burst of writes; the caller drops it
	task automatic write_corner(rbsi_pkg::cfg_reg_t idx, logic [31:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		box_corner[idx] = val;
	endtask

	task automatic write_stray_index(logic [rbsi_pkg::CFG_IDX_W-1:0] idx);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= $urandom;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic drain_results();
		ray_valid <= 0;
		while (pending_hits.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic send_ray(ray_row_t r);
		if (!calm && $urandom_range(0, 5) == 0) begin
			ray_valid <= 0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		ray_valid <= 1;
		origin_x <= r.ox; origin_y <= r.oy; origin_z <= r.oz;
		dir_x <= r.dx; dir_y <= r.dy; dir_z <= r.dz;
		@(posedge clk);
		while (ray_stall) @(posedge clk);
		pending_hits.insert(pending_hits.size(), r.has_exp ? r.exp_res : slab_hit(r));
	endtask

	// result side: random stall bursts, checked at the edge
	initial begin
		int burst;
		burst = 0;
		forever begin
			@(posedge clk);
			if (res_valid && !res_stall) begin
				if (pending_hits.size() == 0) begin
					$display("%0t: unexpected result dist=%0d outcome=%0d", $time,
						distance, outcome);
					errors++;
				end else begin
					slab_res_t e;
					e = pending_hits.pop_front();
					if (distance !== e.dist_val) begin
						$display("%0t: distance exp %0d got %0d", $time, e.dist_val,
							distance);
						errors++;
					end
					if (outcome !== e.code) begin
						$display("%0t: outcome exp %0d got %0d", $time, e.code, outcome);
						errors++;
					end
					if (inside_res !== e.in_box) begin
						$display("%0t: inside exp %0d got %0d", $time, e.in_box,
							inside_res);
						errors++;
					end
				end
			end
			if (burst > 0) burst--;
			else if (!calm && $urandom_range(0, 7) == 0) burst = $urandom_range(1, 15);
			res_stall <= burst > 0;
		end
	end

	function automatic logic signed [15:0] rand_dir();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return $urandom;
			default: return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
		endcase
	endfunction

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 4))
			0: return $urandom;
			default: return $signed(32'($urandom_range(0, 32'h00200000))) - 32'sh00100000;
		endcase
	endfunction

	ray_row_t directed [$];

	task automatic add_row(ray_row_t r);
		directed.insert(directed.size(), r);
	endtask

	function automatic ray_row_t mk(int ox, int oy, int oz, int dx, int dy, int dz);
		ray_row_t r;
		r.ox = ox; r.oy = oy; r.oz = oz;
		r.dx = dx; r.dy = dy; r.dz = dz;
		r.has_exp = 0;
		return r;
	endfunction

	initial begin
		ray_row_t r;
		for (int i = 0; i < 6; i++) box_corner[i] = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// zero box after reset: ray from origin along the +x+y+z diagonal grazes it
		r = mk(0, 0, 0, 16384, 16384, 16384);
		r.has_exp = 1;
		r.exp_res = '{0, rbsi_pkg::OUT_HIT_AHEAD, 0};
		add_row(r);
		// far off-axis, box lies behind: miss
		r = mk(32'h00100000, 0, 0, 0, 16384, 0);
		r.has_exp = 1;
		r.exp_res = '{0, rbsi_pkg::OUT_MISS_BEHIND, 0};
		add_row(r);
		foreach (directed[i]) send_ray(directed[i]);
		drain_results();

		// unit box -1..1
		write_corner(rbsi_pkg::REG_X_LOW, 32'hffff0000);
		write_corner(rbsi_pkg::REG_X_HIGH, 32'h00010000);
		write_corner(rbsi_pkg::REG_Y_LOW, 32'hffff0000);
		write_corner(rbsi_pkg::REG_Y_HIGH, 32'h00010000);
		write_corner(rbsi_pkg::REG_Z_LOW, 32'hffff0000);
		write_corner(rbsi_pkg::REG_Z_HIGH, 32'h00010000);
		write_stray_index(3'd6);
		write_stray_index(3'd7);
		cfg_valid <= 0;
		directed.delete();
		add_row(mk(0, 0, 0, 16384, 0, 0));                      // inside
		add_row(mk(32'hfffb0000, 0, 0, 16384, 0, 0));           // hit ahead
		add_row(mk(32'h00050000, 0, 0, 16384, 0, 0));           // hit behind
		add_row(mk(32'h00050000, 32'h00050000, 0, 16384, 0, 0)); // miss behind
		add_row(mk(32'hfffb0000, 32'h00050000, 0, 16384, 0, 0)); // miss behind
		add_row(mk(32'h80000000, 0, 0, 16384, 0, 0));           // miss ahead
		add_row(mk(32'h7fffffff, 32'h80000000, 32'h7fffffff, -16384, 1, -1));
		add_row(mk(0, 0, 0, 16'sh7fff, 16'sh8000, 0));           // beyond +-1.0
		add_row(mk(32'hfffb0000, 0, 0, -16384, 0, 0));
		add_row(mk(32'h00000001, 32'hffffffff, 0, 1, -1, 16384));
		foreach (directed[i]) send_ray(directed[i]);
		drain_results();

		// inverted, extreme box
		write_corner(rbsi_pkg::REG_X_LOW, 32'h7fffffff);
		write_corner(rbsi_pkg::REG_X_HIGH, 32'h80000000);
		write_corner(rbsi_pkg::REG_Y_LOW, 32'h7fffffff);
		write_corner(rbsi_pkg::REG_Y_HIGH, 32'h80000000);
		write_corner(rbsi_pkg::REG_Z_LOW, 32'h00010000);
		write_corner(rbsi_pkg::REG_Z_HIGH, 32'hffff0000);
		cfg_valid <= 0;
		send_ray(mk(0, 0, 0, 16384, 16384, 16384));
		send_ray(mk(0, 0, 32'h00050000, 16384, 0, -16384));
		drain_results();

		for (int phase = 0; phase < 8; phase++) begin
			for (int k = 0; k < 6; k++) begin
				logic signed [31:0] c;
				c = phase == 7 ? $urandom : rand_coord();
				if (k % 2 == 1 && $urandom_range(0, 9) != 0 && c < box_corner[k-1])
					c = box_corner[k-1] + $urandom_range(0, 32'h00040000);
				write_corner(rbsi_pkg::cfg_reg_t'(k), c);
			end
			cfg_valid <= 0;
			if (phase == 7) calm = 1;
			for (int n = 0; n < 200; n++) begin
				r = mk(rand_coord(), rand_coord(), rand_coord(), rand_dir(), rand_dir(),
					rand_dir());
				send_ray(r);
			end
			drain_results();
		end

		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule
